>>> src/q16alu_pkg.sv
// Shared types and constants for the Q16.16 arithmetic unit.
// No dependencies; imported by q16_16_fixed_point_alu.
package q16alu_pkg;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_F2I = 2'd2,
    OP_ABS = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DIV_ZERO = 3'd1,
    ST_DIV_OVF  = 3'd2,
    ST_NAN_INF  = 3'd3,
    ST_TOO_BIG  = 3'd4
  } status_e;

  // One quotient bit is resolved per divider stage.
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned MantBits  = 23;
  localparam logic [7:0]  ExpMax    = 8'd255;
  localparam logic [7:0]  ExpOffset = 8'd134;   // 127 + 7
  localparam logic [7:0]  ExpTiny   = 8'd111;   // below this the value truncates to 0
  localparam logic [7:0]  ExpHuge   = 8'd141;   // above this the magnitude is 2^15 or more

  typedef struct packed {
    op_e         op;
    status_e     st;
    logic        neg;
    logic [31:0] res;
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] dvs;
    logic [31:0] quo;
  } stage_t;

endpackage

>>> src/q16_16_fixed_point_alu.sv
// Signed Q16.16 arithmetic unit: multiply, divide, float-to-fixed and abs.
// Depends on q16alu_pkg.
//
// Usage: one operation per input beat, chosen by req_type_i; one result beat
// comes back per input beat, in order, on result_value_o and status_code_o.
// Both channels use valid/ready. The unit is a fixed pipeline of 34 register
// stages: an input stage that prepares operands, float conversion and abs,
// 32 divider stages that each resolve one quotient bit (the multiply runs in
// the first of them), and an output register. It accepts one beat per cycle
// whenever the receiver takes results. The 32-stage restoring divider sets
// the depth. When the receiver stalls, the whole pipeline holds and
// in_ready_o falls only while the output register is full and not being
// taken, so nothing is lost or repeated. Reset clears all valid bits;
// payload registers are not reset. A nonzero status always comes with a
// zero result.
module q16_16_fixed_point_alu (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              req_type_i,
  input  logic signed [31:0]      operand_a_i,
  input  logic signed [31:0]      operand_b_i,
  input  logic [31:0]             float_bits_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [31:0]      result_value_o,
  output logic [2:0]              status_code_o
);
  import q16alu_pkg::*;

  stage_t      pipe_q [0:DivSteps];
  stage_t      pipe_d [0:DivSteps];
  logic        vld_q  [0:DivSteps];
  logic        adv;

  logic        out_vld_q;
  logic [31:0] out_res_q, out_res_d;
  status_e     out_st_q, out_st_d;
  op_e         out_op_q;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Input stage: operand magnitudes, early divide checks, float and abs.
  logic [31:0] mag_a, mag_b;
  logic [7:0]  fexp;
  logic [23:0] mant;
  logic [7:0]  rsh;
  logic [7:0]  lsh;
  logic [31:0] fmag;

  always_comb begin
    mag_a = operand_a_i[31] ? (32'd0 - operand_a_i) : operand_a_i;
    mag_b = operand_b_i[31] ? (32'd0 - operand_b_i) : operand_b_i;
    fexp  = float_bits_i[30:23];
    mant  = {1'b1, float_bits_i[MantBits-1:0]};
    lsh   = fexp - ExpOffset;
    rsh   = ExpOffset - fexp;
    if (fexp > ExpOffset) begin
      fmag = {8'd0, mant} << lsh[2:0];
    end else begin
      fmag = {8'd0, mant} >> rsh[4:0];
    end

    pipe_d[0]     = '0;
    pipe_d[0].op  = op_e'(req_type_i);
    pipe_d[0].st  = ST_OK;
    pipe_d[0].neg = operand_a_i[31] ^ operand_b_i[31];
    case (op_e'(req_type_i))
      OP_MUL: begin
        pipe_d[0].res = operand_a_i;
        pipe_d[0].dvs = operand_b_i;
      end
      OP_DIV: begin
        pipe_d[0].rem = {16'd0, mag_a[31:16]};
        pipe_d[0].num = {mag_a[15:0], 16'd0};
        pipe_d[0].dvs = mag_b;
        if (mag_b == 32'd0) begin
          pipe_d[0].st = ST_DIV_ZERO;
        end else if ({16'd0, mag_a[31:16]} >= mag_b) begin
          // The quotient needs more than 32 magnitude bits.
          pipe_d[0].st = ST_DIV_OVF;
        end
      end
      OP_F2I: begin
        if (fexp == 8'd0 || fexp < ExpTiny) begin
          pipe_d[0].res = '0;
        end else if (fexp == ExpMax) begin
          pipe_d[0].st = ST_NAN_INF;
        end else if (fexp > ExpHuge) begin
          pipe_d[0].st = ST_TOO_BIG;
        end else begin
          pipe_d[0].res = float_bits_i[31] ? (32'd0 - fmag) : fmag;
        end
      end
      OP_ABS: begin
        pipe_d[0].res = (!operand_a_i[31] && operand_a_i != 32'sd0) ?
                        operand_a_i : (32'd0 - operand_a_i);
      end
      default: begin
        pipe_d[0].res = '0;
      end
    endcase
  end

  // Divider stages; the first one also holds the multiplier.
  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    logic [32:0] trial;
    logic        fits;
    logic [63:0] prod;

    always_comb begin
      trial     = {pipe_q[k-1].rem, pipe_q[k-1].num[31]};
      fits      = trial >= {1'b0, pipe_q[k-1].dvs};
      prod      = '0;
      pipe_d[k] = pipe_q[k-1];
      pipe_d[k].rem = fits ? 32'(trial - {1'b0, pipe_q[k-1].dvs}) : trial[31:0];
      pipe_d[k].num = {pipe_q[k-1].num[30:0], 1'b0};
      pipe_d[k].quo = {pipe_q[k-1].quo[30:0], fits};
      if (k == 1 && pipe_q[k-1].op == OP_MUL) begin
        prod = 64'($signed(pipe_q[k-1].res) * $signed(pipe_q[k-1].dvs));
        pipe_d[k].res = prod[47:16];
      end
    end
  end

  for (genvar k = 0; k <= DivSteps; k++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // Output stage: sign and range fix for the quotient, zero result on any nonzero status.
  logic [31:0] quo;
  always_comb begin
    quo       = pipe_q[DivSteps].quo;
    out_res_d = pipe_q[DivSteps].res;
    out_st_d  = pipe_q[DivSteps].st;
    if (pipe_q[DivSteps].op == OP_DIV) begin
      out_res_d = '0;
      if (pipe_q[DivSteps].st == ST_OK) begin
        if (pipe_q[DivSteps].neg) begin
          // A negative quotient may reach -2^31 but no further.
          if (quo[31] && (quo[30:0] != 31'd0)) begin
            out_st_d = ST_DIV_OVF;
          end else begin
            out_res_d = 32'd0 - quo;
          end
        end else if (quo[31]) begin
          out_st_d = ST_DIV_OVF;
        end else begin
          out_res_d = quo;
        end
      end
    end else if (pipe_q[DivSteps].st != ST_OK) begin
      out_res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= out_res_d;
      out_st_q  <= out_st_d;
      out_op_q  <= pipe_q[DivSteps].op;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_value_o = out_res_q;
  assign status_code_o  = out_st_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_st_q != ST_OK |-> out_res_q == 32'd0)
    else $error("nonzero status with nonzero result");

  a_div_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_st_q == ST_DIV_ZERO || out_st_q == ST_DIV_OVF) |-> out_op_q == OP_DIV)
    else $error("divide status on a non-divide result");

  a_f2i_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_st_q == ST_NAN_INF || out_st_q == ST_TOO_BIG) |-> out_op_q == OP_F2I)
    else $error("float status on a non-float result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q[DivSteps]) && $stable(vld_q[0]))
    else $error("pipeline moved during a stall");

endmodule

>>> tb/sv/q16_16_fixed_point_alu_checker.sv
// Checker for the Q16.16 arithmetic unit: watches both channels, predicts
// each result and compares it. Depends on q16alu_pkg.
`timescale 1ns / 100ps

module q16_16_fixed_point_alu_checker
  import q16alu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  input  logic [31:0]        float_bits_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] result_value_i,
  input  logic [2:0]         status_code_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [31:0] value;
    status_e     st;
  } alu_result_t;

  alu_result_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic alu_result_t convert_float(logic [31:0] x);
    alu_result_t r;
    logic [7:0]  e;
    logic [31:0] mant;
    logic [31:0] mag;
    int          sh;
    r.value = '0;
    r.st    = ST_OK;
    e       = x[30:23];
    mant    = {8'd0, 1'b1, x[22:0]};
    if (e == 8'd0) return r;
    if (e == ExpMax) begin
      r.st = ST_NAN_INF;
      return r;
    end
    sh = int'(e) - int'(ExpOffset);
    if (sh > 7) begin
      r.st = ST_TOO_BIG;
      return r;
    end
    if (sh < -int'(MantBits)) mag = '0;
    else if (sh > 0) mag = mant << sh;
    else mag = mant >> (-sh);
    r.value = x[31] ? -mag : mag;
    return r;
  endfunction

  function automatic alu_result_t predict_result(op_e op, logic signed [31:0] a,
                                                 logic signed [31:0] b,
                                                 logic [31:0] fb);
    alu_result_t      r;
    logic signed [63:0] p;
    logic signed [63:0] q;
    r.value = '0;
    r.st    = ST_OK;
    case (op)
      OP_MUL: begin
        p       = 64'(a) * 64'(b);
        p       = p >>> 16;
        r.value = p[31:0];
      end
      OP_DIV: begin
        if (b == 0) r.st = ST_DIV_ZERO;
        else begin
          // SystemVerilog signed division truncates toward zero.
          q = (64'(a) <<< 16) / 64'(b);
          if (q > 64'sd2147483647 || q < -64'sd2147483648) r.st = ST_DIV_OVF;
          else r.value = q[31:0];
        end
      end
      OP_F2I: r = convert_float(fb);
      default: r.value = (a > 0) ? a : -a;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    alu_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_result(op_e'(req_type_i), operand_a_i,
                                            operand_b_i, float_bits_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", result_value_i, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (result_value_i !== want.value)
            report_mismatch("result_value", result_value_i, want.value);
          if (status_code_i !== want.st)
            report_mismatch("status_code", 32'(status_code_i), 32'(want.st));
        end
      end
    end
  end

endmodule

>>> tb/sv/q16_16_fixed_point_alu_test.sv
// Testbench top for the Q16.16 arithmetic unit: drives directed and random
// operations with random gaps and stalls. Depends on q16alu_pkg and the checker.
`timescale 1ns / 100ps

module q16_16_fixed_point_alu_test;
  import q16alu_pkg::*;

  localparam int NumRandom = 450;
  localparam int IdleLimit = 4000;
  localparam int DrainCycles = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         req_type_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic [31:0]        float_bits_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic [2:0]         status_code_o;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  q16_16_fixed_point_alu u_top (.*);

  q16_16_fixed_point_alu_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .req_type_i,
    .operand_a_i, .operand_b_i, .float_bits_i, .out_valid_i(out_valid_o),
    .out_ready_i, .result_value_i(result_value_o), .status_code_i(status_code_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Half the time no gap, otherwise mostly a short one, now and then a long one.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0001_0000;
      5: return 32'hffff_0000;
      default: return $urandom();
    endcase
  endfunction

  // Builds floats with exponents concentrated around the interesting range.
  function automatic logic [31:0] random_float();
    logic [7:0] e;
    case ($urandom_range(0, 9))
      0: e = 8'd0;
      1: e = ExpMax;
      2: e = 8'($urandom_range(0, 255));
      default: e = 8'($urandom_range(ExpTiny - 2, ExpHuge + 2));
    endcase
    return {1'($urandom()), e, 23'($urandom())};
  endfunction

  // Valid drops only for a gap, so beats without a gap follow back to back.
  task automatic send_beat(op_e op, logic [31:0] a, logic [31:0] b, logic [31:0] fb);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= op;
    operand_a_i  <= a;
    operand_b_i  <= b;
    float_bits_i <= fb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    logic [31:0] a;
    logic [31:0] b;
    op_e         op;
    op = op_e'($urandom_range(0, 3));
    a  = ($urandom_range(0, 3) == 0) ? edge_word() : $urandom();
    b  = ($urandom_range(0, 3) == 0) ? edge_word() : $urandom();
    // Keep many divides in range so the quotient path is exercised.
    if (op == OP_DIV && $urandom_range(0, 1)) a = $signed(a) >>> $urandom_range(8, 20);
    if (op == OP_DIV && $urandom_range(0, 7) == 0) b = '0;
    send_beat(op, a, b, random_float());
  endtask

  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) < 70) out_ready_i <= 1'b1;
    else if ($urandom_range(0, 19) == 0) out_ready_i <= 1'b0;
    else out_ready_i <= ~out_ready_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("q16_16_fixed_point_alu_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed part: extremes, every operation and the special cases.
    send_beat(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
    send_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
    send_beat(OP_MUL, 32'hffff_0000, 32'h0001_8000, 32'h0);
    send_beat(OP_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0);
    send_beat(OP_DIV, 32'h0001_0000, 32'h0, 32'h0);
    send_beat(OP_DIV, 32'h7fff_ffff, 32'h0000_0001, 32'h0);
    send_beat(OP_DIV, 32'h8000_0000, 32'h0001_0000, 32'h0);
    send_beat(OP_DIV, 32'h8000_0000, 32'hffff_0000, 32'h0);
    send_beat(OP_DIV, 32'hfffd_0000, 32'h0002_0000, 32'h0);
    send_beat(OP_DIV, 32'h0000_0001, 32'h7fff_ffff, 32'h0);
    send_beat(OP_F2I, 32'h0, 32'h0, 32'h0000_0000);
    send_beat(OP_F2I, 32'h0, 32'h0, 32'h8000_0001);
    send_beat(OP_F2I, 32'h0, 32'h0, 32'h7f80_0000);
    send_beat(OP_F2I, 32'h0, 32'h0, 32'hffc0_0001);
    send_beat(OP_F2I, 32'h0, 32'h0, 32'h4700_0000);
    send_beat(OP_F2I, 32'h0, 32'h0, 32'hc6ff_fffe);
    send_beat(OP_F2I, 32'h0, 32'h0, 32'h3780_0000);
    send_beat(OP_F2I, 32'h0, 32'h0, 32'h377f_ffff);
    send_beat(OP_F2I, 32'h0, 32'h0, 32'hbfc0_0000);
    send_beat(OP_ABS, 32'h8000_0000, 32'h0, 32'h0);
    send_beat(OP_ABS, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
    send_beat(OP_ABS, 32'hffff_ffff, 32'h0, 32'h0);
    send_beat(OP_ABS, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < NumRandom; i++) send_random();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("q16_16_fixed_point_alu_test OK");
    else $display("q16_16_fixed_point_alu_test NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
src/q16alu_pkg.sv
src/q16_16_fixed_point_alu.sv
tb/sv/q16_16_fixed_point_alu_checker.sv
tb/sv/q16_16_fixed_point_alu_test.sv
